@@ rtl/idq_pkg.sv @@
package idq_pkg;

    typedef enum logic [2:0] {
        CMD_APPEND     = 3'd0,
        CMD_PREPEND    = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_INSERT     = 3'd4,
        CMD_ERASE      = 3'd5,
        CMD_CLEAR      = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;

    // shift command broadcast to every cell of the row
    typedef struct packed {
        logic open_gap;
        logic close_gap;
    } shift_t;

endpackage

@@ rtl/idq_cell.sv @@
module idq_cell
    import idq_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IDX_W = 4
)
(
    input  logic                     clk,
    input  shift_t                   shift,
    input  logic [IDX_W-1:0]         idx,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    output logic signed [DATA_W-1:0] slot,
    output logic signed [DATA_W-1:0] tap
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [DATA_W-1:0] slot_reg;
    logic signed [DATA_W-1:0] slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (shift.open_gap)
        begin
            if (MY_IDX > idx)
            begin
                slot_next = left_data;
            end
            else if (MY_IDX == idx)
            begin
                slot_next = value;
            end
        end
        else if (shift.close_gap)
        begin
            if (MY_IDX >= idx)
            begin
                slot_next = right_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;
    // word seen by the read side when this cell is addressed
    assign tap  = (MY_IDX == idx) ? slot_reg : '0;

endmodule

@@ rtl/indexed_deque_core.sv @@
// channel   | handshake          | fields
// ----------+--------------------+-------------------------------
// command   | start / busy       | command, value, position
// result    | done (strobe)      | data_out, count, status
//
// one command word is taken per clock; busy stays low
// the result word appears on done in the cycle after acceptance
// every cell of the row shifts in the same cycle
// reset clears the element count and the result strobe; slot contents are kept
// the receiver cannot stall: each result is shown for one cycle only
module indexed_deque_core
    import idq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                command,
    input  logic signed [DATA_W-1:0]  value,
    input  logic [POS_W-1:0]          position,
    output logic                      done,
    output logic signed [DATA_W-1:0]  data_out,
    output logic [COUNT_W-1:0]        count,
    output logic [1:0]                status
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         fill_next;
    logic                     done_reg;
    logic signed [DATA_W-1:0] data_out_reg;
    logic [COUNT_W-1:0]       count_reg;
    status_t                  status_reg;

    logic                     accept;
    cmd_t                     cmd;
    shift_t                   shift;
    logic [IDX_W-1:0]         idx;
    logic                     take;
    status_t                  st;
    logic                     full;
    logic                     empty;
    logic [CMP_W-1:0]         pos_w;
    logic [CMP_W-1:0]         fill_w;
    logic signed [DATA_W-1:0] slots [CAPACITY];
    logic signed [DATA_W-1:0] taps  [CAPACITY];
    logic signed [DATA_W-1:0] read_word;

    assign accept = start && !busy;
    assign busy   = 1'b0;
    assign cmd    = cmd_t'(command);
    assign full   = (fill_reg == FULL_CNT);
    assign empty  = (fill_reg == '0);
    assign pos_w  = CMP_W'(position);
    assign fill_w = CMP_W'(fill_reg);

    always_comb
    begin
        shift     = '0;
        idx       = '0;
        take      = 1'b0;
        st        = ST_OK;
        fill_next = fill_reg;
        case (cmd)
            CMD_APPEND:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    shift.open_gap = 1'b1;
                    idx            = IDX_W'(fill_reg);
                    fill_next      = fill_reg + 1'b1;
                end
            end
            CMD_PREPEND:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    shift.open_gap = 1'b1;
                    fill_next      = fill_reg + 1'b1;
                end
            end
            CMD_POP_BACK:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    shift.close_gap = 1'b1;
                    take            = 1'b1;
                    idx             = IDX_W'(fill_reg - 1'b1);
                    fill_next       = fill_reg - 1'b1;
                end
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    shift.close_gap = 1'b1;
                    take            = 1'b1;
                    fill_next       = fill_reg - 1'b1;
                end
            end
            CMD_INSERT:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else if (pos_w == '0 || pos_w > fill_w + 1'b1)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    shift.open_gap = 1'b1;
                    idx            = IDX_W'(pos_w - 1'b1);
                    fill_next      = fill_reg + 1'b1;
                end
            end
            CMD_ERASE:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else if (pos_w == '0 || pos_w > fill_w)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    shift.close_gap = 1'b1;
                    take            = 1'b1;
                    idx             = IDX_W'(pos_w - 1'b1);
                    fill_next       = fill_reg - 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                fill_next = '0;
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
        if (!accept)
        begin
            shift     = '0;
            fill_next = fill_reg;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        idq_cell #(
            .INDEX (i),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk        (clk),
            .shift      (shift),
            .idx        (idx),
            .value      (value),
            .left_data  ((i == 0) ? value : slots[(i == 0) ? 0 : i - 1]),
            .right_data ((i == CAPACITY - 1) ? '0
                                             : slots[(i == CAPACITY - 1) ? i : i + 1]),
            .slot       (slots[i]),
            .tap        (taps[i])
        );
    end

    always_comb
    begin
        read_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            read_word = read_word | taps[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_out_reg <= take ? read_word : '0;
            count_reg    <= COUNT_W'(fill_next);
            status_reg   <= st;
        end
    end

    assign done     = done_reg;
    assign data_out = data_out_reg;
    assign count    = count_reg;
    assign status   = status_reg;

endmodule

@@ rtl/idq_checker.sv @@
module idq_checker
    import idq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [2:0]                command,
    input  logic                      done,
    input  logic signed [DATA_W-1:0]  data_out,
    input  logic [COUNT_W-1:0]        count,
    input  logic [1:0]                status
);

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

    // every accepted word gives exactly one result in the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (done == $past(start && !busy)))
        else $error("result strobe does not match accepted word");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (data_out == '0))
        else $error("failed command returned data");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (count == '0))
        else $error("empty status with nonzero count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (count == FULL_COUNT))
        else $error("full status with wrong count");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_CLEAR)
            |=> (done && count == '0 && status == ST_OK && data_out == '0))
        else $error("clear did not empty the deque");

endmodule

bind indexed_deque_core idq_checker #(
    .CAPACITY (CAPACITY)
) u_idq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .command  (command),
    .done     (done),
    .data_out (data_out),
    .count    (count),
    .status   (status)
);

@@ dv/tb.sv @@
module tb;
    import idq_pkg::*;

    localparam int CAPACITY = 16;
    localparam int IDLE_LIMIT = 2000;
    localparam logic [2:0] CMD_UNDEF = 3'd7;

    typedef struct {
        logic signed [DATA_W-1:0] data;
        logic [COUNT_W-1:0]       count;
        status_t                  status;
    } result_word_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [2:0]                command;
    logic signed [DATA_W-1:0]  value;
    logic [POS_W-1:0]          position;
    logic                      done;
    logic signed [DATA_W-1:0]  data_out;
    logic [COUNT_W-1:0]        count;
    logic [1:0]                status;

    logic signed [DATA_W-1:0]  deque_slots [CAPACITY];
    int                        deque_fill;
    result_word_t              pending_results [$];

    bit sender_gaps;
    int error_count;
    int words_sent;
    int results_checked;
    int full_hits;
    int empty_hits;
    int range_hits;
    int peak_fill;
    int idle_cycles;

    indexed_deque_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .command  (command),
        .value    (value),
        .position (position),
        .done     (done),
        .data_out (data_out),
        .count    (count),
        .status   (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void deque_place(input int idx, input logic signed [DATA_W-1:0] v);
        for (int i = deque_fill; i > idx; i--)
            deque_slots[i] = deque_slots[i - 1];
        deque_slots[idx] = v;
        deque_fill++;
    endfunction

    function automatic logic signed [DATA_W-1:0] deque_take(input int idx);
        logic signed [DATA_W-1:0] v;
        v = deque_slots[idx];
        for (int i = idx; i + 1 < deque_fill; i++)
            deque_slots[i] = deque_slots[i + 1];
        deque_fill--;
        return v;
    endfunction

    // apply one command word to the local deque and queue the result it should give
    function automatic void predict_result(input logic [2:0] cmd,
                                           input logic signed [DATA_W-1:0] val,
                                           input logic [POS_W-1:0] pos);
        result_word_t w;
        bit           is_full;
        bit           is_empty;
        is_full  = deque_fill >= CAPACITY;
        is_empty = deque_fill == 0;
        w.data   = '0;
        w.status = ST_OK;
        case (cmd)
            CMD_APPEND:
                if (is_full) w.status = ST_FULL;
                else deque_place(deque_fill, val);
            CMD_PREPEND:
                if (is_full) w.status = ST_FULL;
                else deque_place(0, val);
            CMD_POP_BACK:
                if (is_empty) w.status = ST_EMPTY;
                else w.data = deque_take(deque_fill - 1);
            CMD_POP_FRONT:
                if (is_empty) w.status = ST_EMPTY;
                else w.data = deque_take(0);
            CMD_INSERT:
                if (is_full) w.status = ST_FULL;
                else if (pos == 0 || int'(pos) > deque_fill + 1) w.status = ST_RANGE;
                else deque_place(int'(pos) - 1, val);
            CMD_ERASE:
                if (is_empty) w.status = ST_EMPTY;
                else if (pos == 0 || int'(pos) > deque_fill) w.status = ST_RANGE;
                else w.data = deque_take(int'(pos) - 1);
            CMD_CLEAR:
                deque_fill = 0;
            default:
                ;
        endcase
        w.count = COUNT_W'(deque_fill);
        if (w.status == ST_FULL) full_hits++;
        if (w.status == ST_EMPTY) empty_hits++;
        if (w.status == ST_RANGE) range_hits++;
        if (deque_fill > peak_fill) peak_fill = deque_fill;
        pending_results.insert(pending_results.size(), w);
    endfunction

    task automatic send_word(input logic [2:0] cmd, input logic signed [DATA_W-1:0] val,
                             input logic [POS_W-1:0] pos);
        int gap;
        gap = 0;
        if (sender_gaps && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 13);
        repeat (gap)
        begin
            @(negedge clk);
            start    = 1'b0;
            command  = 3'($urandom);
            value    = $urandom;
            position = 5'($urandom);
        end
        @(negedge clk);
        start    = 1'b1;
        command  = cmd;
        value    = val;
        position = pos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_result(cmd, val, pos);
        words_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic test_empty_deque();
        send_word(CMD_POP_BACK, 32'h1234_5678, 5'd1);
        send_word(CMD_POP_FRONT, 32'h0, 5'd0);
        send_word(CMD_ERASE, 32'h0, 5'd1);
        send_word(CMD_UNDEF, 32'hffff_ffff, 5'd31);
        send_word(CMD_INSERT, 32'h5555_aaaa, 5'd0);
        send_word(CMD_INSERT, 32'haaaa_5555, 5'd2);
        send_word(CMD_PREPEND, 32'h8000_0000, 5'd0);
    endtask

    task automatic test_positions_and_extremes();
        send_word(CMD_APPEND, 32'h7fff_ffff, 5'd31);
        send_word(CMD_INSERT, 32'hffff_ffff, 5'd1);
        send_word(CMD_INSERT, 32'h0, 5'd4);
        send_word(CMD_ERASE, 32'h0, 5'd0);
        send_word(CMD_ERASE, 32'h0, 5'd5);
        send_word(CMD_INSERT, 32'h1, 5'd31);
        send_word(CMD_ERASE, 32'h0, 5'd4);
        send_word(CMD_ERASE, 32'h0, 5'd1);
        send_word(CMD_POP_FRONT, 32'h0, 5'd16);
        send_word(CMD_POP_BACK, 32'h0, 5'd17);
        send_word(CMD_APPEND, 32'h0000_0001, 5'd0);
        send_word(CMD_CLEAR, 32'hffff_ffff, 5'd31);
        send_word(CMD_POP_BACK, 32'h0, 5'd0);
    endtask

    task automatic test_fill_and_drain();
        int n;
        n = 0;
        while (deque_fill < CAPACITY)
        begin
            send_word((n % 2 == 0) ? CMD_APPEND : CMD_PREPEND, $urandom, 5'($urandom));
            n++;
        end
        send_word(CMD_APPEND, $urandom, 5'($urandom));
        send_word(CMD_PREPEND, $urandom, 5'($urandom));
        send_word(CMD_INSERT, $urandom, 5'd5);
        // full takes priority over a bad position
        send_word(CMD_INSERT, $urandom, 5'd31);
        send_word(CMD_INSERT, $urandom, 5'd17);
        send_word(CMD_ERASE, 32'h0, 5'd16);
        send_word(CMD_INSERT, $urandom, 5'd16);
        send_word(CMD_ERASE, 32'h0, 5'd17);
        while (deque_fill > 0)
        begin
            send_word((n % 2 == 0) ? CMD_POP_FRONT : CMD_POP_BACK, $urandom, 5'($urandom));
            n++;
        end
        send_word(CMD_POP_FRONT, 32'h0, 5'd0);
        send_word(CMD_ERASE, 32'h0, 5'd17);
    endtask

    task automatic test_random_mix(input int n_words);
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] val;
        logic [POS_W-1:0]         pos;
        int                       roll;
        bit                       growing;
        growing = 1'b1;
        for (int i = 0; i < n_words; i++)
        begin
            if (deque_fill >= CAPACITY) growing = 1'b0;
            else if (deque_fill == 0) growing = 1'b1;
            else if ($urandom_range(0, 29) == 0) growing = !growing;
            roll = $urandom_range(0, 99);
            if (roll < 2)
                cmd = CMD_CLEAR;
            else if (roll < 4)
                cmd = CMD_UNDEF;
            else if ((roll < 74) == growing)
                case ($urandom_range(0, 2))
                    0: cmd = CMD_APPEND;
                    1: cmd = CMD_PREPEND;
                    default: cmd = CMD_INSERT;
                endcase
            else
                case ($urandom_range(0, 2))
                    0: cmd = CMD_POP_BACK;
                    1: cmd = CMD_POP_FRONT;
                    default: cmd = CMD_ERASE;
                endcase
            case ($urandom_range(0, 9))
                0: val = 32'h8000_0000;
                1: val = 32'h7fff_ffff;
                2: val = 32'hffff_ffff;
                3: val = 32'h0;
                default: val = $urandom;
            endcase
            if ($urandom_range(0, 6) == 0)
                pos = 5'($urandom);
            else if (cmd == CMD_INSERT)
                pos = 5'($urandom_range(1, deque_fill + 1));
            else if (cmd == CMD_ERASE && deque_fill > 0)
                pos = 5'($urandom_range(1, deque_fill));
            else
                pos = 5'($urandom);
            send_word(cmd, val, pos);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_word_t w;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with none expected: data %h count %0d status %0d",
                         $time, data_out, count, status);
                error_count++;
            end
            else
            begin
                w = pending_results.pop_front();
                results_checked++;
                if (data_out !== w.data)
                begin
                    $display("%0t: data_out expected %h actual %h", $time, w.data, data_out);
                    error_count++;
                end
                if (count !== w.count)
                begin
                    $display("%0t: count expected %0d actual %0d", $time, w.count, count);
                    error_count++;
                end
                if (status !== w.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, w.status, status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout, %0d result words outstanding", $time,
                     pending_results.size());
            $display("** indexed_deque_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        start       = 1'b0;
        command     = CMD_APPEND;
        value       = '0;
        position    = '0;
        rst_n       = 1'b0;
        sender_gaps = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_deque();
        test_positions_and_extremes();
        wait_for_results();
        test_fill_and_drain();
        test_random_mix(420);
        // hold off until every result is back
        wait_for_results();
        sender_gaps = 1'b0;
        test_random_mix(140);
        wait_for_results();
        repeat (4) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d result words never arrived", $time, pending_results.size());
            error_count++;
        end
        $display("%0d command words sent, %0d results checked, peak fill %0d of %0d",
                 words_sent, results_checked, peak_fill, CAPACITY);
        $display("rejections seen: full %0d, empty %0d, bad position %0d",
                 full_hits, empty_hits, range_hits);
        if (error_count == 0)
            $display("** indexed_deque_core: PASSED **");
        else
            $display("** indexed_deque_core: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/idq_pkg.sv
rtl/idq_cell.sv
rtl/indexed_deque_core.sv
rtl/idq_checker.sv
dv/tb.sv
